@@ hw/rtl/bas_pkg.sv @@
package bas_pkg;

    localparam int MAX_OUT_COLS = 512;
    localparam int COL_AW       = $clog2(MAX_OUT_COLS);
    localparam int SUM_W        = 20;
    localparam int SHADE_COUNT  = 8;
    localparam int DIV_NW       = 20;
    localparam int DIV_DW       = 13;

    // ceil(2^30 / 125), used for x / 1000 = (x >> 3) / 125
    localparam logic [23:0] LUMA_RECIP = 24'd8589935;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_RSC,
        ST_RSR,
        ST_IDLE,
        ST_WSUM,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        DIV_COL,
        DIV_ROW,
        DIV_AREA
    } t_div_sel;

    typedef enum logic [2:0] {
        CFG_IMAGE_WIDTH,
        CFG_IMAGE_HEIGHT,
        CFG_TILE_WIDTH,
        CFG_TILE_HEIGHT,
        CFG_GRAY_MODE,
        CFG_DARK_ON_LIGHT
    } t_cfg_idx;

    typedef struct packed {
        logic     accept;
        logic     clr_wr;
        logic     div_start;
        t_div_sel div_sel;
        logic     load_col;
        logic     load_row;
        logic     acc_wr;
        logic     emit;
    } t_dp_cmd;

    typedef struct packed {
        logic kept;
        logic tile_done;
        logic clr_last;
        logic div_done;
        logic out_free;
    } t_dp_status;

    function automatic logic [7:0] shade_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h40; // @
            3'd1:    c = 8'h23; // #
            3'd2:    c = 8'h25; // %
            3'd3:    c = 8'h2A; // *
            3'd4:    c = 8'h7C; // |
            3'd5:    c = 8'h2D; // -
            3'd6:    c = 8'h2E; // .
            default: c = 8'h20; // space
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/bas_ram.sv @@
module bas_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/bas_div.sv @@
module bas_div
    import bas_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIV_NW-1:0] i_dividend,
    input  logic [DIV_DW-1:0] i_divisor,
    output logic              o_done,
    output logic [DIV_NW-1:0] o_quotient,
    output logic [DIV_DW-1:0] o_remainder
);

    localparam int CW = $clog2(DIV_NW);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [DIV_NW-1:0] r_quo, n_quo;
    logic [DIV_DW-1:0] r_rem, n_rem;
    logic [DIV_DW-1:0] r_dsr, n_dsr;
    logic [DIV_DW-1:0] trial;

    // one quotient bit per cycle, restoring
    always_comb begin
        trial  = {r_rem[DIV_DW-2:0], r_quo[DIV_NW-1]};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            if (trial >= r_dsr) begin
                n_rem = trial - r_dsr;
                n_quo = {r_quo[DIV_NW-2:0], 1'b1};
            end else begin
                n_rem = trial;
                n_quo = {r_quo[DIV_NW-2:0], 1'b0};
            end
            n_cnt = r_cnt + CW'(1);
            if (r_cnt == CW'(DIV_NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

@@ hw/rtl/bas_ctrl.sv @@
module bas_ctrl
    import bas_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_s_tvalid,
    input  t_dp_status i_status,
    output logic       o_s_tready,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_pend, n_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_pend        = r_pend | i_cfg_we;
        o_s_tready    = 1'b0;
        o_cmd         = '0;
        o_cmd.div_sel = DIV_AREA;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (r_pend) begin
                    // tile geometry may have changed: rebuild the tile position
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_COL;
                    n_pend          = i_cfg_we;
                    n_state         = ST_RSC;
                end else begin
                    o_s_tready = 1'b1;
                    if (i_s_tvalid) begin
                        o_cmd.accept = 1'b1;
                        if (i_status.kept) begin
                            n_state = ST_WSUM;
                        end
                    end
                end
            end
            ST_RSC: begin
                if (i_status.div_done) begin
                    o_cmd.load_col  = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DIV_ROW;
                    n_state         = ST_RSR;
                end
            end
            ST_RSR: begin
                if (i_status.div_done) begin
                    o_cmd.load_row = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_WSUM: n_state = ST_MUL;
            ST_MUL:  n_state = ST_ACC;
            ST_ACC: begin
                o_cmd.acc_wr = 1'b1;
                if (i_status.tile_done) begin
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_DIV;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (i_status.div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

@@ hw/rtl/bas_dp.sv @@
module bas_dp
    import bas_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [12:0] i_cfg_wdata,
    input  logic [23:0] i_pixel,
    input  logic        i_m_tready,
    input  t_dp_cmd     i_cmd,
    output t_dp_status  o_status,
    output logic        o_m_tvalid,
    output logic [7:0]  o_char_code,
    output logic [2:0]  o_shade_level,
    output logic        o_row_end,
    output logic        o_frame_end
);

    // configuration
    logic [12:0] r_img_w, r_img_h;
    logic [6:0]  r_tile_w, r_tile_h;
    logic        r_gray_mode, r_dark;

    // raster position
    logic [11:0] r_col, r_row, r_tcol, r_col_base, r_row_base;
    logic [5:0]  r_cin, r_rin;

    // per-item latches
    logic [23:0]       r_rgb;
    logic [COL_AW-1:0] r_addr;
    logic              r_first, r_done, r_rend, r_fend;
    logic [17:0]       r_wsum;
    logic [7:0]        r_hue;
    logic [38:0]       r_prod;
    logic [COL_AW-1:0] r_clr_addr;

    // output register
    logic       r_m_valid;
    logic [7:0] r_m_char;
    logic [2:0] r_m_level;
    logic       r_m_rend, r_m_fend;

    logic [12:0] w_c, h_c;
    logic [6:0]  tw_c, th_c;
    logic [13:0] area_full;
    logic        col_kept, row_kept, kept_now, first_now, done_now;
    logic        rend_now, last_trow, last_col, last_row, cin_wrap, rin_wrap;
    logic [7:0]  gray;
    logic [SUM_W-1:0]  acc_sum;
    logic [SUM_W-1:0]  ram_rdata;
    logic [DIV_NW-1:0] div_nd, div_quo;
    logic [DIV_DW-1:0] div_dd, div_rem;
    logic              div_done;
    logic [2:0]        level, idx;

    function automatic logic [7:0] hue_bucket(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
        logic [7:0] v;
        if (r == g && r == b) begin
            v = (r < 8'd128) ? 8'd31 : 8'd255;
        end else if (r >= g && g >= b) begin
            v = 8'd223;
        end else if (g >= r && r >= b) begin
            v = 8'd191;
        end else if (g >= b && b >= r) begin
            v = 8'd159;
        end else if (b >= g && g >= r) begin
            v = 8'd127;
        end else if (b >= r && r >= g) begin
            v = 8'd95;
        end else begin
            v = 8'd63;
        end
        return v;
    endfunction

    always_comb begin
        w_c  = (r_img_w == '0) ? 13'd1 : ((r_img_w > 13'd4096) ? 13'd4096 : r_img_w);
        h_c  = (r_img_h == '0) ? 13'd1 : ((r_img_h > 13'd4096) ? 13'd4096 : r_img_h);
        tw_c = (r_tile_w == '0) ? 7'd1 : ((r_tile_w > 7'd64) ? 7'd64 : r_tile_w);
        th_c = (r_tile_h == '0) ? 7'd1 : ((r_tile_h > 7'd64) ? 7'd64 : r_tile_h);
        area_full = {7'b0, tw_c} * {7'b0, th_c};

        // a tile is kept when it lies wholly inside the image and the accumulator row
        col_kept  = (({1'b0, r_col_base} + {6'b0, tw_c}) <= w_c) && (r_tcol[11:COL_AW] == '0);
        row_kept  = ({1'b0, r_row_base} + {6'b0, th_c}) <= h_c;
        kept_now  = col_kept && row_kept;
        first_now = (r_cin == '0) && (r_rin == '0);
        cin_wrap  = ({1'b0, r_cin} + 7'd1) == tw_c;
        rin_wrap  = ({1'b0, r_rin} + 7'd1) == th_c;
        done_now  = cin_wrap && rin_wrap;
        rend_now  = col_kept && (((r_tcol[11:COL_AW] == '0) && (&r_tcol[COL_AW-1:0])) ||
                    (({2'b0, r_col_base} + {6'b0, tw_c, 1'b0}) > {1'b0, w_c}));
        last_trow = ({2'b0, r_row_base} + {6'b0, th_c, 1'b0}) > {1'b0, h_c};
        last_col  = ({1'b0, r_col} + 13'd1) >= w_c;
        last_row  = ({1'b0, r_row} + 13'd1) >= h_c;

        gray    = r_gray_mode ? r_hue : r_prod[37:30];
        acc_sum = r_first ? {{(SUM_W-8){1'b0}}, gray}
                          : ram_rdata + {{(SUM_W-8){1'b0}}, gray};

        case (i_cmd.div_sel)
            DIV_COL: begin
                div_nd = {{(DIV_NW-12){1'b0}}, r_col};
                div_dd = {6'b0, tw_c};
            end
            DIV_ROW: begin
                div_nd = {{(DIV_NW-12){1'b0}}, r_row};
                div_dd = {6'b0, th_c};
            end
            default: begin
                div_nd = acc_sum;
                div_dd = area_full[12:0];
            end
        endcase

        // average is at most 255, level is its top three bits
        level = div_quo[7:5];
        idx   = r_dark ? ~level : level;
    end

    bas_ram #(
        .WIDTH(SUM_W),
        .DEPTH(MAX_OUT_COLS)
    ) u_sums (
        .i_clk  (i_clk),
        .i_we   (i_cmd.clr_wr | i_cmd.acc_wr),
        .i_waddr(i_cmd.clr_wr ? r_clr_addr : r_addr),
        .i_wdata(i_cmd.clr_wr ? {SUM_W{1'b0}} : acc_sum),
        .i_re   (i_cmd.accept),
        .i_raddr(r_tcol[COL_AW-1:0]),
        .o_rdata(ram_rdata)
    );

    bas_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_nd),
        .i_divisor  (div_dd),
        .o_done     (div_done),
        .o_quotient (div_quo),
        .o_remainder(div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w     <= 13'd640;
            r_img_h     <= 13'd480;
            r_tile_w    <= 7'd8;
            r_tile_h    <= 7'd8;
            r_gray_mode <= 1'b0;
            r_dark      <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_IMAGE_WIDTH:   r_img_w     <= i_cfg_wdata;
                CFG_IMAGE_HEIGHT:  r_img_h     <= i_cfg_wdata;
                CFG_TILE_WIDTH:    r_tile_w    <= i_cfg_wdata[6:0];
                CFG_TILE_HEIGHT:   r_tile_h    <= i_cfg_wdata[6:0];
                CFG_GRAY_MODE:     r_gray_mode <= i_cfg_wdata[0];
                CFG_DARK_ON_LIGHT: r_dark      <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_tcol     <= '0;
            r_col_base <= '0;
            r_row_base <= '0;
            r_cin      <= '0;
            r_rin      <= '0;
        end else if (i_cmd.accept) begin
            if (last_col) begin
                r_col      <= '0;
                r_cin      <= '0;
                r_tcol     <= '0;
                r_col_base <= '0;
                if (last_row) begin
                    r_row      <= '0;
                    r_rin      <= '0;
                    r_row_base <= '0;
                end else begin
                    r_row <= r_row + 12'd1;
                    if (rin_wrap) begin
                        r_rin      <= '0;
                        r_row_base <= r_row_base + {5'b0, th_c};
                    end else begin
                        r_rin <= r_rin + 6'd1;
                    end
                end
            end else begin
                r_col <= r_col + 12'd1;
                if (cin_wrap) begin
                    r_cin      <= '0;
                    r_tcol     <= r_tcol + 12'd1;
                    r_col_base <= r_col_base + {5'b0, tw_c};
                end else begin
                    r_cin <= r_cin + 6'd1;
                end
            end
        end else begin
            if (i_cmd.load_col) begin
                r_tcol     <= div_quo[11:0];
                r_cin      <= div_rem[5:0];
                r_col_base <= r_col - {6'b0, div_rem[5:0]};
            end
            if (i_cmd.load_row) begin
                r_rin      <= div_rem[5:0];
                r_row_base <= r_row - {6'b0, div_rem[5:0]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + COL_AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_rgb   <= i_pixel;
            r_addr  <= r_tcol[COL_AW-1:0];
            r_first <= first_now;
            r_done  <= done_now;
            r_rend  <= rend_now;
            r_fend  <= rend_now && last_trow;
        end
        // gray pipeline runs freely off the latched pixel
        r_wsum <= 18'd299 * {10'b0, r_rgb[7:0]} + 18'd587 * {10'b0, r_rgb[15:8]}
                + 18'd114 * {10'b0, r_rgb[23:16]};
        r_hue  <= hue_bucket(r_rgb[7:0], r_rgb[15:8], r_rgb[23:16]);
        r_prod <= {24'b0, r_wsum[17:3]} * {15'b0, LUMA_RECIP};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_m_char  <= shade_char(idx);
            r_m_level <= level;
            r_m_rend  <= r_rend;
            r_m_fend  <= r_fend;
        end
    end

    always_comb begin
        o_status.kept      = kept_now;
        o_status.tile_done = r_done;
        o_status.clr_last  = &r_clr_addr;
        o_status.div_done  = div_done;
        o_status.out_free  = !r_m_valid || i_m_tready;
    end

    assign o_m_tvalid    = r_m_valid;
    assign o_char_code   = r_m_char;
    assign o_shade_level = r_m_level;
    assign o_row_end     = r_m_rend;
    assign o_frame_end   = r_m_fend;

endmodule

@@ hw/rtl/block_average_ascii_shader_core.sv @@
// Block-average shader: RGB pixels in raster order go in on the s_axis channel,
// one shade character per whole tile comes out on the m_axis channel.
// Configuration goes through the write port (i_cfg_we, i_cfg_addr, i_cfg_wdata)
// while no pixel is in flight; indexes are image width, image height, tile width,
// tile height, gray mode and dark-on-light.
// A pixel outside any whole tile is accepted with no further work. A pixel
// inside a kept tile goes through latch, weighted sum, reciprocal multiply and
// accumulator read-add-write on the 512-entry sum memory. The pixel that closes
// a tile also runs a shift-subtract divide by the tile area, after which its
// character is loaded into the output register once that register is free.
// Any configuration write makes the next pixel wait while the
// same divider rebuilds the tile position from the current raster position.
// After reset every entry of the sum memory is cleared with s_axis tready low.
// The output register lets one finished character wait while the next pixels
// are taken; a second finished character waits inside until m_axis tready rises.
module block_average_ascii_shader_core
    import bas_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [12:0] i_cfg_wdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // red, green, blue
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // char_code, shade_level, zero fill
    output logic        o_m_axis_tlast,   // row_end
    output logic        o_m_axis_tuser    // frame_end
);

    t_dp_cmd    cmd;
    t_dp_status status;
    logic [7:0] char_code;
    logic [2:0] shade_level;

    bas_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_s_tvalid(i_s_axis_tvalid),
        .i_status  (status),
        .o_s_tready(o_s_axis_tready),
        .o_cmd     (cmd)
    );

    bas_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_pixel      (i_s_axis_tdata),
        .i_m_tready   (i_m_axis_tready),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_m_tvalid   (o_m_axis_tvalid),
        .o_char_code  (char_code),
        .o_shade_level(shade_level),
        .o_row_end    (o_m_axis_tlast),
        .o_frame_end  (o_m_axis_tuser)
    );

    assign o_m_axis_tdata = {5'b0, shade_level, char_code};

endmodule
